[sv/rppf_pkg.sv]
// rppf_pkg: shared types, constants and helpers for the rf pulse phase feedback block
// used by rppf_mac, rf_pulse_phase_feedback_top and rppf_checker
// no dependencies
package rppf_pkg;

    localparam int PHASE_W = 15;   // phase registers and phase inputs
    localparam int WEIGHT_W = 16;  // weights and loop gain
    localparam int THRESH_W = 14;
    localparam int AMP_W = 16;
    localparam int COUNT_W = 32;
    localparam int ENABLE_W = 3;
    localparam int CALC_W = 22;    // internal phase arithmetic width
    localparam int ACC_W = 38;     // mac accumulator width
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W = 96;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 2;

    localparam logic signed [CALC_W-1:0] HALF_TURN = 22'sd11520;
    localparam logic signed [CALC_W-1:0] FULL_TURN = 22'sd23040;
    localparam logic [COUNT_W-1:0] FW_DOWN = 32'hFFFF_FFFF;

    // enables register bits
    localparam int EN_FB = 0;
    localparam int EN_FF = 1;
    localparam int EN_REF = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT  = 8'd0,
        CFG_OFFSET    = 8'd1,
        CFG_SLED_W    = 8'd2,
        CFG_ACC_W     = 8'd3,
        CFG_GAIN      = 8'd4,
        CFG_THRESH    = 8'd5,
        CFG_AMP_LIM   = 8'd6,
        CFG_ENABLES   = 8'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_SLED,
        ST_MUL_ACC,
        ST_MEAS,
        ST_ERR,
        ST_MUL_GAIN,
        ST_OUT
    } t_state;

    // mac control: en loads a new value, acc adds the product to the old one
    typedef struct packed {
        logic en;
        logic acc;
    } t_mac_ctl;

    function automatic logic signed [CALC_W-1:0] wrap_once(input logic signed [CALC_W-1:0] v);
        logic signed [CALC_W-1:0] r;
        if (v > HALF_TURN) begin
            r = v - FULL_TURN;
        end else if (v < -HALF_TURN) begin
            r = v + FULL_TURN;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[sv/rppf_mac.sv]
// rppf_mac: shared signed multiplier with accumulator register
// depends on rppf_pkg
module rppf_mac (
    input  logic                                 i_clk,
    input  rppf_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [rppf_pkg::CALC_W-1:0]   i_a,
    input  logic signed [rppf_pkg::WEIGHT_W-1:0] i_b,
    output logic signed [rppf_pkg::ACC_W-1:0]    o_acc
);
    import rppf_pkg::*;

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] w_prod;

    assign w_prod = ACC_W'(i_a) * ACC_W'(i_b);

    always_comb begin
        if (i_ctl.acc) begin
            n_acc = r_acc + w_prod;
        end else begin
            n_acc = w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

[sv/rf_pulse_phase_feedback_top.sv]
// rf_pulse_phase_feedback_top: pulse-to-pulse rf phase feedback, sequencer and state
// depends on rppf_pkg and rppf_mac
//
// One pulse beat in, one result beat out. From the accepted input beat to the result
// register each pulse runs through the states MUL_SLED, MUL_ACC, MEAS, ERR, MUL_GAIN and
// OUT (three passes through the single 22x16 signed multiply-accumulate unit for the two
// weighted phases and the loop gain, plus measurement, error and output steps), then back
// to IDLE, the only state in which a pulse can be taken: the sequencer holds s_axis_tready
// low in every other state. A result waits in the output register until taken, and the
// next pulse may be accepted while it waits; the output step stalls while an older result
// is still waiting. Configuration writes are always accepted (o_cfg_ready is high) and
// should be done while no pulse is in flight; indexes beyond 7 are ignored. Phases are in
// 1/64 degree.
module rf_pulse_phase_feedback_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // cfg write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rppf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rppf_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // pulse input
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sled_phase[14:0], acc_phase[29:15], ref_phase[44:30], sled_amp[60:45],
    // pulse_count[92:61], zero fill[95:93]
    input  logic [rppf_pkg::IN_DATA_W-1:0]         s_axis_tdata,
    // result output
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // measured_phase[16:0], phase_error[33:17], ff_adjust[50:34], fb_adjust[68:51],
    // status_word[77:69], missed_pulses[109:78], zero fill[111:110]
    output logic [rppf_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // ff_valid[0], fb_valid[1]
    output logic [rppf_pkg::OUT_USER_W-1:0]        m_axis_tuser
);
    import rppf_pkg::*;

    // configuration registers
    logic signed [PHASE_W-1:0]  r_phase_setpoint;
    logic signed [PHASE_W-1:0]  r_phase_offset;
    logic signed [WEIGHT_W-1:0] r_sled_weight;
    logic signed [WEIGHT_W-1:0] r_acc_weight;
    logic signed [WEIGHT_W-1:0] r_loop_gain;
    logic [THRESH_W-1:0]        r_error_threshold;
    logic [COUNT_W-1:0]         r_amp_limits;
    logic [ENABLE_W-1:0]        r_enables;

    // pulse state
    logic signed [PHASE_W-1:0]  r_prev_setpoint;
    logic signed [PHASE_W-1:0]  r_prev_offset;
    logic                       r_prev_valid;
    logic [COUNT_W-1:0]         r_prev_pulse_count;
    logic [COUNT_W-1:0]         r_missed;

    // captured input beat
    logic signed [PHASE_W-1:0]  r_sled;
    logic signed [PHASE_W-1:0]  r_acc;
    logic signed [PHASE_W-1:0]  r_ref;
    logic [AMP_W-1:0]           r_amp;
    logic [COUNT_W-1:0]         r_pc;

    // intermediate results
    logic signed [CALC_W-1:0]   r_meas;
    logic signed [CALC_W-1:0]   r_err;
    logic signed [CALC_W-1:0]   r_ffa;
    logic                       r_ff;

    // output register
    logic                       r_out_valid;
    logic [OUT_DATA_W-1:0]      r_out_data;
    logic [OUT_USER_W-1:0]      r_out_user;

    t_state r_state;
    t_state n_state;

    t_mac_ctl                   w_mac_ctl;
    logic signed [CALC_W-1:0]   w_mac_a;
    logic signed [WEIGHT_W-1:0] w_mac_b;
    logic signed [ACC_W-1:0]    w_mac_acc;

    logic                       w_in_acc;
    logic                       w_out_load;
    logic signed [CALC_W-1:0]   w_meas_raw;
    logic signed [CALC_W-1:0]   w_sp;
    logic signed [CALC_W-1:0]   w_err_raw;
    logic                       w_ff;
    logic                       w_sp_ok;
    logic                       w_off_ok;
    logic [CALC_W-1:0]          w_err_abs;
    logic                       w_err_big;
    logic [AMP_W-1:0]           w_lo;
    logic [AMP_W-1:0]           w_hi;
    logic                       w_fb;
    logic [17:0]                w_fba;
    logic [16:0]                w_ffa;
    logic [8:0]                 w_status;
    logic signed [COUNT_W+1:0]  w_pc_diff;
    logic                       w_missed_inc;
    logic [COUNT_W-1:0]         w_missed_next;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_setpoint  <= '0;
            r_phase_offset    <= '0;
            r_sled_weight     <= '0;
            r_acc_weight      <= '0;
            r_loop_gain       <= '0;
            r_error_threshold <= '0;
            r_amp_limits      <= '0;
            r_enables         <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SETPOINT: r_phase_setpoint  <= i_cfg_data[PHASE_W-1:0];
                CFG_OFFSET:   r_phase_offset    <= i_cfg_data[PHASE_W-1:0];
                CFG_SLED_W:   r_sled_weight     <= i_cfg_data[WEIGHT_W-1:0];
                CFG_ACC_W:    r_acc_weight      <= i_cfg_data[WEIGHT_W-1:0];
                CFG_GAIN:     r_loop_gain       <= i_cfg_data[WEIGHT_W-1:0];
                CFG_THRESH:   r_error_threshold <= i_cfg_data[THRESH_W-1:0];
                CFG_AMP_LIM:  r_amp_limits      <= i_cfg_data[COUNT_W-1:0];
                CFG_ENABLES:  r_enables         <= i_cfg_data[ENABLE_W-1:0];
                default: ;
            endcase
        end
    end

    rppf_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (w_mac_ctl),
        .i_a   (w_mac_a),
        .i_b   (w_mac_b),
        .o_acc (w_mac_acc)
    );

    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // measured phase: floored weighted sum, minus offset and optional reference
    assign w_meas_raw = CALC_W'($signed(w_mac_acc[31:14])) - CALC_W'(r_phase_offset)
                      - (r_enables[EN_REF] ? CALC_W'(r_ref) : CALC_W'(0));

    assign w_sp_ok  = (CALC_W'(r_prev_setpoint) <= HALF_TURN) &&
                      (CALC_W'(r_prev_setpoint) >= -HALF_TURN);
    assign w_off_ok = (CALC_W'(r_prev_offset) <= HALF_TURN) &&
                      (CALC_W'(r_prev_offset) >= -HALF_TURN);
    assign w_ff = r_enables[EN_FF] && r_prev_valid &&
                  (((r_phase_setpoint != r_prev_setpoint) && w_sp_ok) ||
                   ((r_phase_offset != r_prev_offset) && w_off_ok));
    assign w_sp = w_ff ? CALC_W'(r_prev_setpoint) : CALC_W'(r_phase_setpoint);
    assign w_err_raw = ((r_sled_weight != '0) || (r_acc_weight != '0)) ?
                       (w_sp - r_meas) : CALC_W'(0);

    // feedback gating and status
    assign w_err_abs = r_err[CALC_W-1] ? CALC_W'(-r_err) : CALC_W'(r_err);
    assign w_err_big = w_err_abs >= CALC_W'(r_error_threshold);
    assign w_lo = r_amp_limits[AMP_W-1:0];
    assign w_hi = r_amp_limits[COUNT_W-1:AMP_W];
    assign w_fb = !w_err_big && (r_amp > w_lo) && (r_amp < w_hi) && r_enables[EN_FB];
    assign w_fba = w_fb ? w_mac_acc[29:12] : 18'd0;
    assign w_ffa = r_ff ? r_ffa[16:0] : 17'd0;
    assign w_status = {r_acc_weight > 0, r_sled_weight > 0, r_amp <= w_lo, r_amp >= w_hi,
                       w_err_big, r_enables, r_pc == FW_DOWN};

    assign w_pc_diff = $signed({2'b00, r_pc}) - $signed({2'b00, r_prev_pulse_count});
    assign w_missed_inc = (r_prev_pulse_count != '0) && (w_pc_diff > 34'sd1);
    assign w_missed_next = w_missed_inc ? r_missed + COUNT_W'(1) : r_missed;

    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    // sequencer
    always_comb begin
        n_state = r_state;
        s_axis_tready = 1'b0;
        w_mac_ctl = '0;
        w_mac_a = CALC_W'(r_sled);
        w_mac_b = r_sled_weight;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_MUL_SLED;
                end
            end
            ST_MUL_SLED: begin
                w_mac_ctl.en = 1'b1;
                n_state = ST_MUL_ACC;
            end
            ST_MUL_ACC: begin
                w_mac_ctl.en = 1'b1;
                w_mac_ctl.acc = 1'b1;
                w_mac_a = CALC_W'(r_acc);
                w_mac_b = r_acc_weight;
                n_state = ST_MEAS;
            end
            ST_MEAS: n_state = ST_ERR;
            ST_ERR: n_state = ST_MUL_GAIN;
            ST_MUL_GAIN: begin
                w_mac_ctl.en = 1'b1;
                w_mac_a = r_err;
                w_mac_b = r_loop_gain;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sled <= s_axis_tdata[14:0];
            r_acc  <= s_axis_tdata[29:15];
            r_ref  <= s_axis_tdata[44:30];
            r_amp  <= s_axis_tdata[60:45];
            r_pc   <= s_axis_tdata[92:61];
        end
        if (r_state == ST_MEAS) begin
            r_meas <= wrap_once(w_meas_raw);
        end
        if (r_state == ST_ERR) begin
            r_err <= wrap_once(w_err_raw);
            r_ff  <= w_ff;
            r_ffa <= CALC_W'(r_phase_setpoint) - r_meas;
        end
        if (w_out_load) begin
            r_out_data <= {2'b00, w_missed_next, w_status, w_fba, w_ffa,
                           r_err[16:0], r_meas[16:0]};
            r_out_user <= {w_fb, r_ff};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_setpoint    <= '0;
            r_prev_offset      <= '0;
            r_prev_valid       <= 1'b0;
            r_prev_pulse_count <= '0;
            r_missed           <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_prev_setpoint    <= r_phase_setpoint;
                r_prev_offset      <= r_phase_offset;
                r_prev_valid       <= 1'b1;
                r_prev_pulse_count <= r_pc;
                r_missed           <= w_missed_next;
                r_out_valid        <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

[sv/rppf_checker.sv]
// rppf_port_checker: port-level assertions for rf_pulse_phase_feedback_top, with bind
// depends on rppf_pkg
module rppf_port_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [rppf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input logic [rppf_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
    import rppf_pkg::*;

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // the sequencer is busy right after taking a pulse
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted pulse");

    a_ff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[50:34] == '0)
        else $error("ff_adjust nonzero without ff_valid");

    a_fb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[68:51] == '0)
        else $error("fb_adjust nonzero without fb_valid");

    // a result is not shown right after its pulse is taken while no older result waits
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared one cycle after a pulse");

endmodule

bind rf_pulse_phase_feedback_top rppf_port_checker u_rppf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
